// ----- src/bmhq_pkg.sv -----
// shared types and constants for the binary min-heap queue
package bmhq_pkg;

    localparam int OUT_KEY_W   = 32;
    localparam int OUT_PAY_W   = 9;
    localparam int TOTAL_W     = 9;

    typedef enum logic
    {
        KIND_INSERT  = 1'b0,
        KIND_EXTRACT = 1'b1
    } kind_t;

    typedef enum logic [1:0]
    {
        ERR_OK    = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2
    } err_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_EX_RD,
        ST_EX_LD,
        ST_DN_RD,
        ST_DN_LEFT,
        ST_DN_RIGHT
    } state_t;

    typedef struct packed
    {
        logic                 out_valid;
        logic [OUT_KEY_W-1:0] out_key;
        logic [OUT_PAY_W-1:0] out_payload;
        err_t                 error_code;
        logic [TOTAL_W-1:0]   entry_total;
    } result_t;

endpackage

// ----- src/bmhq_req_if.sv -----
// request channel: insert or extract operations
interface bmhq_req_if;
    logic                            valid;
    logic                            ready;
    logic                            kind;
    logic [bmhq_pkg::OUT_KEY_W-1:0]  new_key;
    logic [bmhq_pkg::OUT_PAY_W-1:0]  new_payload;

    modport source (output valid, kind, new_key, new_payload, input ready);
    modport sink   (input valid, kind, new_key, new_payload, output ready);
endinterface

// ----- src/bmhq_res_if.sv -----
// result channel: extracted entry, error code and entry count
interface bmhq_res_if;
    logic                            valid;
    logic                            ready;
    logic                            out_valid;
    logic [bmhq_pkg::OUT_KEY_W-1:0]  out_key;
    logic [bmhq_pkg::OUT_PAY_W-1:0]  out_payload;
    logic [1:0]                      error_code;
    logic [bmhq_pkg::TOTAL_W-1:0]    entry_total;

    modport source (output valid, out_valid, out_key, out_payload, error_code, entry_total,
                    input ready);
    modport sink   (input valid, out_valid, out_key, out_payload, error_code, entry_total,
                    output ready);
endinterface

// ----- src/binary_min_heap_queue.sv -----
// binary min-heap priority queue top level
//
//  channel  modport  payload
//  req      sink     kind, new_key, new_payload
//  res      source   out_valid, out_key, out_payload, error_code, entry_total
//
// one request at a time; a result appears for every request
// insert steps UP_RD, UP_CMP per level moved; extract EX_RD, EX_LD, then DN_RD, DN_LEFT,
// DN_RIGHT per level (at most log2 HEAP_DEPTH), set by one key comparator and registered reads
// errored requests skip the memory; reset clears state, entry count and result valid, no memory sweep
// a pending result is held in the output register; the next request is taken meanwhile
module binary_min_heap_queue #(
    parameter int HEAP_DEPTH   = 256,
    parameter int KEY_BITS     = 32,
    parameter int PAYLOAD_BITS = 9
) (
    input  logic        clk,
    input  logic        rst_n,
    bmhq_req_if.sink    req,
    bmhq_res_if.source  res
);

    localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int EW = KEY_BITS + PAYLOAD_BITS;

    logic              idle;
    logic              res_load;
    logic              res_free;
    bmhq_pkg::result_t result;
    logic              res_valid_reg, res_valid_next;
    bmhq_pkg::result_t res_data_reg, res_data_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    logic [AW-1:0] rd_a_addr;
    logic [AW-1:0] rd_b_addr;
    logic [EW-1:0] rd_a_data;
    logic [EW-1:0] rd_b_data;

    assign req.ready = idle;
    assign res_free  = !res_valid_reg || res.ready;

    bmhq_ctrl #(
        .HEAP_DEPTH   (HEAP_DEPTH),
        .KEY_BITS     (KEY_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .AW           (AW),
        .CW           (CW),
        .EW           (EW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (req.valid && idle),
        .kind        (req.kind),
        .new_key     (KEY_BITS'(req.new_key)),
        .new_payload (PAYLOAD_BITS'(req.new_payload)),
        .res_free    (res_free),
        .idle        (idle),
        .res_load    (res_load),
        .result      (result),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_a_addr   (rd_a_addr),
        .rd_b_addr   (rd_b_addr),
        .rd_a_data   (rd_a_data),
        .rd_b_data   (rd_b_data)
    );

    bmhq_store #(
        .DEPTH (HEAP_DEPTH),
        .AW    (AW),
        .EW    (EW)
    ) u_store (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_a_addr (rd_a_addr),
        .rd_b_addr (rd_b_addr),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data)
    );

    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_data_next  = res_data_reg;
        if (res_load)
        begin
            res_valid_next = 1'b1;
            res_data_next  = result;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_data_reg <= res_data_next;
    end

    assign res.valid       = res_valid_reg;
    assign res.out_valid   = res_data_reg.out_valid;
    assign res.out_key     = res_data_reg.out_key;
    assign res.out_payload = res_data_reg.out_payload;
    assign res.error_code  = res_data_reg.error_code;
    assign res.entry_total = res_data_reg.entry_total;

endmodule

// ----- src/bmhq_store.sv -----
// heap entry memory: one write port, two registered read ports
module bmhq_store #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int EW    = 41
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [EW-1:0] wr_data,
    input  logic [AW-1:0] rd_a_addr,
    input  logic [AW-1:0] rd_b_addr,
    output logic [EW-1:0] rd_a_data,
    output logic [EW-1:0] rd_b_data
);

    logic [EW-1:0] mem [DEPTH];
    logic [EW-1:0] rd_a_reg;
    logic [EW-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_a_reg <= mem[rd_a_addr];
        rd_b_reg <= mem[rd_b_addr];
    end

    assign rd_a_data = rd_a_reg;
    assign rd_b_data = rd_b_reg;

endmodule

// ----- src/bmhq_ctrl.sv -----
// sift sequencer with one shared key comparator
module bmhq_ctrl #(
    parameter int HEAP_DEPTH   = 256,
    parameter int KEY_BITS     = 32,
    parameter int PAYLOAD_BITS = 9,
    parameter int AW           = 8,
    parameter int CW           = 9,
    parameter int EW           = 41
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    kind,
    input  logic [KEY_BITS-1:0]     new_key,
    input  logic [PAYLOAD_BITS-1:0] new_payload,
    input  logic                    res_free,
    output logic                    idle,
    output logic                    res_load,
    output bmhq_pkg::result_t       result,
    output logic                    wr_en,
    output logic [AW-1:0]           wr_addr,
    output logic [EW-1:0]           wr_data,
    output logic [AW-1:0]           rd_a_addr,
    output logic [AW-1:0]           rd_b_addr,
    input  logic [EW-1:0]           rd_a_data,
    input  logic [EW-1:0]           rd_b_data
);

    localparam int CHW = CW + 1;

    bmhq_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [AW-1:0]    pos_reg, pos_next;
    logic [EW-1:0]    cur_reg, cur_next;
    logic [EW-1:0]    best_reg, best_next;
    logic             best_left_reg, best_left_next;
    logic             done_reg, done_next;
    bmhq_pkg::result_t res_reg, res_next;

    logic [AW-1:0]       parent_idx;
    logic [CHW-1:0]      left_idx;
    logic [CHW-1:0]      right_idx;
    logic                left_ok;
    logic                right_ok;
    logic [KEY_BITS-1:0] cmp_a;
    logic [KEY_BITS-1:0] cmp_b;
    logic                cmp_lt;

    assign parent_idx = (pos_reg - AW'(1)) >> 1;
    assign left_idx   = CHW'({pos_reg, 1'b1});
    assign right_idx  = CHW'({pos_reg, 1'b0}) + CHW'(2);
    assign left_ok    = left_idx < CHW'(count_reg);
    assign right_ok   = right_idx < CHW'(count_reg);

    // the one comparator, its operands chosen by the step in progress
    always_comb
    begin
        unique case (state_reg)
            bmhq_pkg::ST_DN_LEFT:
            begin
                cmp_a = rd_a_data[EW-1:PAYLOAD_BITS];
                cmp_b = cur_reg[EW-1:PAYLOAD_BITS];
            end
            bmhq_pkg::ST_DN_RIGHT:
            begin
                cmp_a = rd_b_data[EW-1:PAYLOAD_BITS];
                cmp_b = best_reg[EW-1:PAYLOAD_BITS];
            end
            default:
            begin
                cmp_a = cur_reg[EW-1:PAYLOAD_BITS];
                cmp_b = rd_a_data[EW-1:PAYLOAD_BITS];
            end
        endcase
    end

    assign cmp_lt = cmp_a < cmp_b;

    always_comb
    begin
        unique case (state_reg) inside
            bmhq_pkg::ST_UP_RD, bmhq_pkg::ST_UP_CMP:
            begin
                rd_a_addr = parent_idx;
                rd_b_addr = parent_idx;
            end
            bmhq_pkg::ST_EX_RD, bmhq_pkg::ST_EX_LD:
            begin
                rd_a_addr = '0;
                rd_b_addr = count_reg[AW-1:0];
            end
            default:
            begin
                rd_a_addr = left_idx[AW-1:0];
                rd_b_addr = right_idx[AW-1:0];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bmhq_pkg::ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        cur_reg       <= cur_next;
        best_reg      <= best_next;
        best_left_reg <= best_left_next;
        res_reg       <= res_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        cur_next       = cur_reg;
        best_next      = best_reg;
        best_left_next = best_left_reg;
        done_next      = done_reg;
        res_next       = res_reg;
        wr_en          = 1'b0;
        wr_addr        = pos_reg;
        wr_data        = cur_reg;
        res_load       = 1'b0;
        idle           = 1'b0;

        unique case (state_reg)
            bmhq_pkg::ST_IDLE:
            begin
                // a finished request waits here until the result slot frees
                if (done_reg)
                begin
                    if (res_free)
                    begin
                        res_load  = 1'b1;
                        done_next = 1'b0;
                    end
                end
                else
                begin
                    idle = 1'b1;
                    if (start)
                    begin
                        res_next.out_valid   = 1'b0;
                        res_next.out_key     = '0;
                        res_next.out_payload = '0;
                        res_next.error_code  = bmhq_pkg::ERR_OK;
                        if (bmhq_pkg::kind_t'(kind) == bmhq_pkg::KIND_INSERT)
                        begin
                            if (count_reg == CW'(HEAP_DEPTH))
                            begin
                                res_next.error_code = bmhq_pkg::ERR_FULL;
                                done_next           = 1'b1;
                            end
                            else
                            begin
                                cur_next   = {new_key, new_payload};
                                pos_next   = count_reg[AW-1:0];
                                count_next = count_reg + CW'(1);
                                state_next = bmhq_pkg::ST_UP_RD;
                            end
                        end
                        else if (count_reg == '0)
                        begin
                            res_next.error_code = bmhq_pkg::ERR_EMPTY;
                            done_next           = 1'b1;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                            state_next = bmhq_pkg::ST_EX_RD;
                        end
                        res_next.entry_total = bmhq_pkg::TOTAL_W'(count_next);
                    end
                end
            end

            bmhq_pkg::ST_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    wr_en      = 1'b1;
                    done_next  = 1'b1;
                    state_next = bmhq_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = bmhq_pkg::ST_UP_CMP;
                end
            end

            bmhq_pkg::ST_UP_CMP:
            begin
                wr_en = 1'b1;
                if (cmp_lt)
                begin
                    // parent moves down into the hole
                    wr_data    = rd_a_data;
                    pos_next   = parent_idx;
                    state_next = bmhq_pkg::ST_UP_RD;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = bmhq_pkg::ST_IDLE;
                end
            end

            bmhq_pkg::ST_EX_RD:
            begin
                state_next = bmhq_pkg::ST_EX_LD;
            end

            bmhq_pkg::ST_EX_LD:
            begin
                res_next.out_valid   = 1'b1;
                res_next.out_key     = bmhq_pkg::OUT_KEY_W'(rd_a_data[EW-1:PAYLOAD_BITS]);
                res_next.out_payload = bmhq_pkg::OUT_PAY_W'(rd_a_data[PAYLOAD_BITS-1:0]);
                cur_next             = rd_b_data;
                pos_next             = '0;
                state_next           = bmhq_pkg::ST_DN_RD;
            end

            bmhq_pkg::ST_DN_RD:
            begin
                state_next = bmhq_pkg::ST_DN_LEFT;
            end

            bmhq_pkg::ST_DN_LEFT:
            begin
                if (left_ok && cmp_lt)
                begin
                    best_next      = rd_a_data;
                    best_left_next = 1'b1;
                end
                else
                begin
                    best_next      = cur_reg;
                    best_left_next = 1'b0;
                end
                state_next = bmhq_pkg::ST_DN_RIGHT;
            end

            bmhq_pkg::ST_DN_RIGHT:
            begin
                wr_en = 1'b1;
                if (right_ok && cmp_lt)
                begin
                    wr_data    = rd_b_data;
                    pos_next   = right_idx[AW-1:0];
                    state_next = bmhq_pkg::ST_DN_RD;
                end
                else if (best_left_reg)
                begin
                    wr_data    = best_reg;
                    pos_next   = left_idx[AW-1:0];
                    state_next = bmhq_pkg::ST_DN_RD;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = bmhq_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = bmhq_pkg::ST_IDLE;
            end
        endcase
    end

    assign result = res_reg;

endmodule

// ----- dv/tb.sv -----
// testbench for the binary min-heap queue: random and directed requests against a heap predictor
module tb;

    localparam int DEPTH           = 256;
    localparam int RANDOM_REQUESTS = 900;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int SETTLE_CYCLES   = 60;

    logic clk;
    logic rst_n;

    bmhq_req_if req_ch ();
    bmhq_res_if res_ch ();

    binary_min_heap_queue dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    // predicted heap contents
    logic [bmhq_pkg::OUT_KEY_W-1:0] heap_key [DEPTH];
    logic [bmhq_pkg::OUT_PAY_W-1:0] heap_pay [DEPTH];
    int                             heap_count;

    bmhq_pkg::result_t pending_results [$];
    int                mismatches;
    int                cycles;
    int                burst_left;
    int                stall_mode;
    int                stall_left;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic void swap_entries(input int a, input int b);
        logic [bmhq_pkg::OUT_KEY_W-1:0] k;
        logic [bmhq_pkg::OUT_PAY_W-1:0] p;
        k = heap_key[a];
        p = heap_pay[a];
        heap_key[a] = heap_key[b];
        heap_pay[a] = heap_pay[b];
        heap_key[b] = k;
        heap_pay[b] = p;
    endfunction

    // applies one request to the predicted heap and returns the result it should give
    function automatic bmhq_pkg::result_t heap_apply(input bmhq_pkg::kind_t k,
                                                     input logic [bmhq_pkg::OUT_KEY_W-1:0] key,
                                                     input logic [bmhq_pkg::OUT_PAY_W-1:0] pay);
        bmhq_pkg::result_t r;
        int                pos;
        int                up;
        int                best;
        int                lc;
        int                rc;
        bit                settled;
        r = '0;
        r.error_code = bmhq_pkg::ERR_OK;
        settled = 1'b0;
        if (k == bmhq_pkg::KIND_INSERT)
        begin
            if (heap_count >= DEPTH)
                r.error_code = bmhq_pkg::ERR_FULL;
            else
            begin
                pos = heap_count;
                heap_key[pos] = key;
                heap_pay[pos] = pay;
                heap_count++;
                while (pos != 0 && !settled)
                begin
                    up = (pos - 1) / 2;
                    if (heap_key[pos] < heap_key[up])
                    begin
                        swap_entries(pos, up);
                        pos = up;
                    end
                    else
                        settled = 1'b1;
                end
            end
        end
        else
        begin
            if (heap_count == 0)
                r.error_code = bmhq_pkg::ERR_EMPTY;
            else
            begin
                r.out_valid   = 1'b1;
                r.out_key     = heap_key[0];
                r.out_payload = heap_pay[0];
                heap_count--;
                heap_key[0] = heap_key[heap_count];
                heap_pay[0] = heap_pay[heap_count];
                pos = 0;
                while (!settled)
                begin
                    best = pos;
                    lc   = 2 * pos + 1;
                    rc   = 2 * pos + 2;
                    // left child first, then right, strict less-than only
                    if (lc < heap_count && heap_key[lc] < heap_key[best])
                        best = lc;
                    if (rc < heap_count && heap_key[rc] < heap_key[best])
                        best = rc;
                    if (best == pos)
                        settled = 1'b1;
                    else
                    begin
                        swap_entries(best, pos);
                        pos = best;
                    end
                end
            end
        end
        r.entry_total = bmhq_pkg::TOTAL_W'(heap_count);
        return r;
    endfunction

    function automatic logic [bmhq_pkg::OUT_KEY_W-1:0] rand_key();
        logic [bmhq_pkg::OUT_KEY_W-1:0] k;
        case ($urandom_range(0, 9)) inside
            0, 1:    k = $urandom_range(0, 7);
            2:       k = '0;
            3:       k = '1;
            default: k = $urandom;
        endcase
        return k;
    endfunction

    // sends one request in bursts with random gaps between them
    task automatic send_request(input bmhq_pkg::kind_t k,
                                input logic [bmhq_pkg::OUT_KEY_W-1:0] key,
                                input logic [bmhq_pkg::OUT_PAY_W-1:0] pay);
        int gap;
        if (burst_left == 0)
        begin
            case ($urandom_range(0, 3))
                0:       gap = 0;
                1:       gap = $urandom_range(1, 4);
                default: gap = $urandom_range(5, 40);
            endcase
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 16);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        req_ch.valid       <= 1'b1;
        req_ch.kind        <= k;
        req_ch.new_key     <= key;
        req_ch.new_payload <= pay;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_results.push_back(heap_apply(k, key, pay));
        @(negedge clk);
    endtask

    task automatic report_mismatch(input string what, input bmhq_pkg::result_t want,
                                   input bmhq_pkg::result_t got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("cycle %0d %s: expected v=%0b key=%h pay=%h err=%0d tot=%0d",
                     cycles, what, want.out_valid, want.out_key, want.out_payload,
                     want.error_code, want.entry_total);
            $display("    got v=%0b key=%h pay=%h err=%0d tot=%0d",
                     got.out_valid, got.out_key, got.out_payload, got.error_code,
                     got.entry_total);
        end
    endtask

    always @(posedge clk)
    begin
        bmhq_pkg::result_t got;
        bmhq_pkg::result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got.out_valid   = res_ch.out_valid;
            got.out_key     = res_ch.out_key;
            got.out_payload = res_ch.out_payload;
            got.error_code  = bmhq_pkg::err_t'(res_ch.error_code);
            got.entry_total = res_ch.entry_total;
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", '0, got);
            else
            begin
                want = pending_results.pop_front();
                if (got.out_valid !== want.out_valid || got.out_key !== want.out_key ||
                    got.out_payload !== want.out_payload ||
                    got.error_code !== want.error_code ||
                    got.entry_total !== want.entry_total)
                    report_mismatch("result mismatch", want, got);
            end
        end
    end

    // receiver stalls on its own pattern, switching mode now and then
    initial
    begin
        res_ch.ready = 1'b0;
        stall_mode   = 0;
        stall_left   = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(20, 200);
            end
            stall_left--;
            case (stall_mode)
                0:       res_ch.ready <= 1'b1;
                1:       res_ch.ready <= 1'($urandom_range(0, 1));
                2:       res_ch.ready <= (stall_left % 3 == 0);
                default: res_ch.ready <= (stall_left % 13 == 0);
            endcase
        end
    end

    task automatic test_empty_extract();
        send_request(bmhq_pkg::KIND_EXTRACT, '0, '0);
        send_request(bmhq_pkg::KIND_EXTRACT, '1, '1);
    endtask

    task automatic test_key_extremes();
        send_request(bmhq_pkg::KIND_INSERT, 32'hFFFF_FFFF, 9'h1FF);
        send_request(bmhq_pkg::KIND_INSERT, 32'h0000_0000, 9'h000);
        // top bit set must still sort above anything without it
        send_request(bmhq_pkg::KIND_INSERT, 32'h8000_0000, 9'h155);
        send_request(bmhq_pkg::KIND_INSERT, 32'h7FFF_FFFF, 9'h0AA);
        send_request(bmhq_pkg::KIND_INSERT, 32'h5555_5555, 9'h100);
        send_request(bmhq_pkg::KIND_INSERT, 32'hAAAA_AAAA, 9'h0FF);
        repeat (7)
            send_request(bmhq_pkg::KIND_EXTRACT, '0, '0);
    endtask

    task automatic test_equal_keys();
        send_request(bmhq_pkg::KIND_INSERT, 32'd1, 9'd10);
        for (int i = 1; i <= 6; i++)
            send_request(bmhq_pkg::KIND_INSERT, 32'd5, bmhq_pkg::OUT_PAY_W'(i));
        send_request(bmhq_pkg::KIND_INSERT, 32'd1, 9'd11);
        repeat (9)
            send_request(bmhq_pkg::KIND_EXTRACT, '0, '0);
    endtask

    task automatic test_full_heap();
        while (heap_count < DEPTH)
            send_request(bmhq_pkg::KIND_INSERT, rand_key(),
                         bmhq_pkg::OUT_PAY_W'($urandom_range(0, 511)));
        // a smallest key on a full heap must not get in
        send_request(bmhq_pkg::KIND_INSERT, '0, 9'h1FF);
        send_request(bmhq_pkg::KIND_INSERT, '1, 9'h000);
        repeat (3)
            send_request(bmhq_pkg::KIND_EXTRACT, '0, '0);
        repeat (4)
            send_request(bmhq_pkg::KIND_INSERT, rand_key(),
                         bmhq_pkg::OUT_PAY_W'($urandom_range(0, 511)));
    endtask

    task automatic test_random_mix();
        int sent;
        int phase_left;
        int insert_pct;
        sent       = 0;
        phase_left = 0;
        insert_pct = 50;
        while (sent < RANDOM_REQUESTS)
        begin
            if (phase_left == 0)
            begin
                phase_left = $urandom_range(30, 250);
                case ($urandom_range(0, 2))
                    0:       insert_pct = 80;
                    1:       insert_pct = 20;
                    default: insert_pct = 50;
                endcase
            end
            if ($urandom_range(1, 100) <= insert_pct)
                send_request(bmhq_pkg::KIND_INSERT, rand_key(),
                             bmhq_pkg::OUT_PAY_W'($urandom_range(0, 511)));
            else
                send_request(bmhq_pkg::KIND_EXTRACT, $urandom,
                             bmhq_pkg::OUT_PAY_W'($urandom_range(0, 511)));
            sent++;
            phase_left--;
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.kind        = bmhq_pkg::KIND_INSERT;
        req_ch.new_key     = '0;
        req_ch.new_payload = '0;
        heap_count         = 0;
        burst_left         = 0;
        mismatches         = 0;
        cycles             = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_extract();
        test_key_extremes();
        test_equal_keys();
        test_full_heap();
        test_random_mix();

        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
